// ===== src/life_generation_row_engine_macros.svh =====
// Assertion macros for the files that check their own logic.
`ifndef LIFE_GENERATION_ROW_ENGINE_MACROS_SVH
`define LIFE_GENERATION_ROW_ENGINE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LGR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lgr assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LGR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lgr assertion failed");

`endif

// ===== src/lgr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lgr_pkg;

  localparam int MAX_SIZE = 64;
  localparam int ROW_W = 64;
  localparam int SIZE_W = 7;
  localparam int MIN_SIZE = 3;
  localparam int CNT_W = 4;
  localparam logic [CNT_W-1:0] BIRTH_COUNT = CNT_W'(3);
  localparam logic [CNT_W-1:0] SURVIVE_COUNT = CNT_W'(2);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

  // Control broadcast to every column cell.
  typedef struct packed {
    logic load;
    logic first;
    logic pass;
  } cell_ctrl_t;

  // Bits one cell hands to its neighbors.
  typedef struct packed {
    logic older;
    logic newer;
    logic cur;
  } nbr_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic      first_valid;
    logic      second_valid;
    out_item_t first;
    out_item_t second;
  } out_push_t;

endpackage

`default_nettype wire

// ===== src/lgr_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lgr_cell
  import lgr_pkg::*;
(
  input  wire logic       clk,
  input  wire cell_ctrl_t ctrl,
  input  wire logic       in_grid,
  input  wire logic       interior,
  input  wire logic       cur_bit,
  input  wire nbr_t       left_nb,
  input  wire nbr_t       right_nb,
  output nbr_t            own_nb,
  output logic            next_bit
);

  logic older;
  logic newer;
  logic cur_m;
  logic [CNT_W-1:0] count;
  logic rule_bit;

  assign cur_m = cur_bit & in_grid;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      older <= ctrl.first ? 1'b0 : newer;
      newer <= cur_m;
    end
  end

  assign own_nb = '{older: older, newer: newer, cur: cur_m};

  always_comb begin
    count = CNT_W'(left_nb.older) + CNT_W'(older) + CNT_W'(right_nb.older)
          + CNT_W'(left_nb.newer) + CNT_W'(right_nb.newer)
          + CNT_W'(left_nb.cur) + CNT_W'(cur_m) + CNT_W'(right_nb.cur);
    rule_bit = (count == BIRTH_COUNT) || (newer && (count == SURVIVE_COUNT));
    if (!in_grid) begin
      next_bit = 1'b0;
    end else if (ctrl.pass || !interior) begin
      next_bit = newer;
    end else begin
      next_bit = rule_bit;
    end
  end

endmodule

`default_nettype wire

// ===== src/lgr_out_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lgr_out_fifo
  import lgr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire out_push_t push,
  input  wire logic      pop,
  output logic           room,
  output logic           not_empty,
  output out_item_t      head,
  output logic [FIFO_CW-1:0] level
);

  out_item_t mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW-1:0] wr_ptr_next;
  logic [FIFO_CW-1:0] level_next;
  logic do_pop;

  assign do_pop = pop && not_empty;

  always_comb begin
    wr_ptr_next = wr_ptr + FIFO_AW'(push.first_valid) + FIFO_AW'(push.second_valid);
    level_next = level + FIFO_CW'(push.first_valid) + FIFO_CW'(push.second_valid)
               - FIFO_CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      level <= level_next;
      if (do_pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.first_valid) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.second_valid) begin
      mem[wr_ptr + FIFO_AW'(1)] <= push.second;
    end
  end

  // Room for the two transfers that a final row pushes.
  assign room = level <= FIFO_CW'(FIFO_DEPTH - 2);
  assign not_empty = level != '0;
  assign head = mem[rd_ptr];

endmodule

`default_nettype wire

// ===== src/life_generation_row_engine.sv =====
// Channel   Direction  Payload
// s_*       in         tdata[63:0] row_cells
// m_*       out        tdata[63:0] next_row_cells, tlast last_row
// cfg_*     in         data[6:0] grid_size
//
// One row per cycle is taken while s_tready is high; each later row pushes the
// prior row's result, formed by 64 column cells that trade neighbor bits, into
// a four-entry queue in the same cycle. The final row of a generation pushes two
// transfers, so s_tready needs two free queue entries; it depends only on level.
// Synchronous reset clears the row counter, the queue and sets grid_size to 64.
// A stalled m_tready fills the queue and then holds s_tready low.
`timescale 1ns / 1ps
`default_nettype none
`include "life_generation_row_engine_macros.svh"

module life_generation_row_engine
  import lgr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [ROW_W-1:0]  s_tdata,   // [63:0] row_cells
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [ROW_W-1:0]       m_tdata,   // [63:0] next_row_cells
  output logic                   m_tlast,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [SIZE_W-1:0] cfg_data
);

  logic [SIZE_W-1:0] grid_size;
  logic [SIZE_W-1:0] row_count;
  logic [SIZE_W-1:0] row_count_next;
  logic [SIZE_W-1:0] n_eff;
  logic [SIZE_W:0]   row_count_inc;
  logic s_fire;
  logic cfg_fire;
  logic is_final;
  cell_ctrl_t ctrl;
  nbr_t nb [ROW_W];
  logic [ROW_W-1:0] next_row;
  logic [ROW_W-1:0] cur_row;
  out_push_t push;
  out_item_t head;
  logic room;
  logic [FIFO_CW-1:0] level;

  assign cfg_ready = 1'b1;
  assign cfg_fire = cfg_valid && cfg_ready;
  assign s_tready = room;
  assign s_fire = s_tvalid && s_tready;

  always_comb begin
    if (grid_size < SIZE_W'(MIN_SIZE)) begin
      n_eff = SIZE_W'(MIN_SIZE);
    end else if (grid_size > SIZE_W'(MAX_SIZE)) begin
      n_eff = SIZE_W'(MAX_SIZE);
    end else begin
      n_eff = grid_size;
    end
  end

  assign row_count_inc = {1'b0, row_count} + (SIZE_W+1)'(1);
  assign is_final = (row_count != '0) && (row_count_inc >= {1'b0, n_eff});

  always_comb begin
    row_count_next = row_count;
    if (cfg_fire) begin
      row_count_next = '0;
    end else if (s_fire) begin
      row_count_next = is_final ? '0 : row_count_inc[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= SIZE_W'(MAX_SIZE);
      row_count <= '0;
    end else begin
      row_count <= row_count_next;
      if (cfg_fire) begin
        grid_size <= cfg_data;
      end
    end
  end

  assign ctrl = '{load: s_fire, first: row_count == '0, pass: row_count == SIZE_W'(1)};

  for (genvar x = 0; x < ROW_W; x++) begin : g_col
    logic in_grid;
    logic interior;
    nbr_t left_nb;
    nbr_t right_nb;

    assign in_grid = SIZE_W'(x) < n_eff;
    assign interior = (x >= 1) && ((SIZE_W + 1)'(x + 1) < {1'b0, n_eff});

    if (x == 0) begin : g_left_edge
      assign left_nb = '0;
    end else begin : g_left
      assign left_nb = nb[x-1];
    end
    if (x == ROW_W - 1) begin : g_right_edge
      assign right_nb = '0;
    end else begin : g_right
      assign right_nb = nb[x+1];
    end

    lgr_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .in_grid  (in_grid),
      .interior (interior),
      .cur_bit  (s_tdata[x]),
      .left_nb  (left_nb),
      .right_nb (right_nb),
      .own_nb   (nb[x]),
      .next_bit (next_row[x])
    );

    assign cur_row[x] = nb[x].cur;
  end

  assign push = '{
    first_valid:  s_fire && (row_count != '0),
    second_valid: s_fire && is_final,
    first:        '{row: next_row, last: 1'b0},
    second:       '{row: cur_row, last: 1'b1}
  };

  lgr_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (m_tready),
    .room      (room),
    .not_empty (m_tvalid),
    .head      (head),
    .level     (level)
  );

  assign m_tdata = head.row;
  assign m_tlast = head.last;

  `LGR_ASSERT_SAME(a_level_bound, 1'b1, level <= FIFO_CW'(FIFO_DEPTH))
  `LGR_ASSERT_SAME(a_count_in_grid, 1'b1, row_count < n_eff)
  `LGR_ASSERT_NEXT(a_final_restarts, s_fire && is_final, row_count == '0)

endmodule

`default_nettype wire
